>>> hw/rtl/dd_odo_pkg.sv
// ----------------------------------------------------------------------------
// dd_odo_pkg
// Shared types, constants and the arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package dd_odo_pkg;

  // 1/(2 pi) in Q0.32
  localparam logic [31:0] INV_TWO_PI_Q32   = 32'd683565276;
  // cordic start value, Q1.30, pre-scaled by the cordic gain
  localparam logic [31:0] CORDIC_START_Q30 = 32'd652032874;
  // arc step magnitude cap, 2^40
  localparam logic [40:0] ARC_CAP          = 41'h100_0000_0000;

  // configuration register indexes
  localparam logic [1:0] REG_METRES_PER_TICK = 2'd0;
  localparam logic [1:0] REG_INV_WHEEL_BASE  = 2'd1;
  localparam logic [1:0] REG_ANGLE_ONLY      = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DL,
    ST_DR,
    ST_DS,
    ST_TM,
    ST_BHI,
    ST_BLO,
    ST_BAM,
    ST_COR0,
    ST_STR_Y,
    ST_STR_X,
    ST_STR_FIN,
    ST_COR1,
    ST_ARC_Y,
    ST_ARC_YD,
    ST_ARC_YW,
    ST_ARC_X,
    ST_ARC_XD,
    ST_ARC_XW,
    ST_DONE
  } state_t;

  // cordic result
  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_res_t;

  // divider result
  typedef struct packed {
    logic        done;
    logic [40:0] quot;
  } div_res_t;

  // arctangent of 2^-i as binary angle
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/dd_odo_if.sv
// ----------------------------------------------------------------------------
// dd_odo channel interfaces
// Valid/ready channels for encoder count beats and pose result beats.
// ----------------------------------------------------------------------------
interface dd_odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  modport source (output valid, left_count, right_count, input ready);
  modport sink   (input valid, left_count, right_count, output ready);
endinterface

interface dd_odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic        [31:0] heading;
  modport source (output valid, position_x, position_y, heading, input ready);
  modport sink   (input valid, position_x, position_y, heading, output ready);
endinterface

>>> hw/rtl/dd_odo_cordic.sv
// ----------------------------------------------------------------------------
// dd_odo_cordic
// Iterative rotation cordic: one micro-rotation per cycle, quadrant folding.
// ----------------------------------------------------------------------------
module dd_odo_cordic #(
  parameter int TRIG_ITERATIONS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [31:0]               angle,
  output dd_odo_pkg::cordic_res_t   res
);

  localparam int ITER = (TRIG_ITERATIONS < 30) ? TRIG_ITERATIONS : 30;
  localparam int IW   = $clog2(ITER + 1);

  logic               busy_r;
  logic [IW-1:0]      i_r;
  logic [1:0]         q_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic               done_r;
  logic signed [31:0] cos_r, sin_r;

  logic [1:0]         q_in;
  logic [31:0]        ru;
  logic signed [31:0] x_sh, y_sh;
  logic [31:0]        at;

  // quadrant fold of the start angle
  always_comb begin
    q_in = 2'((angle + 32'h2000_0000) >> 30);
    ru   = angle - {q_in, 30'd0};
    x_sh = x_r >>> i_r;
    y_sh = y_r >>> i_r;
    at   = dd_odo_pkg::atan_bam(5'(i_r));
  end

  // rotation loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        q_r    <= q_in;
        x_r    <= $signed(dd_odo_pkg::CORDIC_START_Q30);
        y_r    <= '0;
        z_r    <= $signed(ru);
      end else if (busy_r) begin
        if (i_r == IW'(ITER)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          case (q_r)
            2'd0:    begin cos_r <= x_r;  sin_r <= y_r;  end
            2'd1:    begin cos_r <= -y_r; sin_r <= x_r;  end
            2'd2:    begin cos_r <= -x_r; sin_r <= -y_r; end
            default: begin cos_r <= y_r;  sin_r <= -x_r; end
          endcase
        end else begin
          i_r <= i_r + 1'b1;
          if (!z_r[31]) begin
            x_r <= x_r - y_sh;
            y_r <= y_r + x_sh;
            z_r <= z_r - $signed(at);
          end else begin
            x_r <= x_r + y_sh;
            y_r <= y_r - x_sh;
            z_r <= z_r + $signed(at);
          end
        end
      end
    end
  end

  assign res.done  = done_r;
  assign res.cos_v = cos_r;
  assign res.sin_v = sin_r;

endmodule

>>> hw/rtl/dd_odo_div.sv
// ----------------------------------------------------------------------------
// dd_odo_div
// Restoring divider, one quotient bit per cycle, for (n * 2^9) / d,
// saturated at 2^40.
// ----------------------------------------------------------------------------
module dd_odo_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [63:0]            n,
  input  logic [63:0]            d,
  output dd_odo_pkg::div_res_t   res
);

  logic        busy_r, done_r, over_r;
  logic [5:0]  cnt_r;
  logic [63:0] r_r;
  logic [40:0] bits_r, q_r, quot_r;
  logic [63:0] d_r;

  logic [64:0] t;
  logic        ge;
  logic [64:0] t_sub;

  // trial subtract
  always_comb begin
    t     = {r_r, bits_r[40]};
    ge    = t >= {1'b0, d_r};
    t_sub = t - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // a quotient of 2^41 or more is already over the cap
        busy_r <= 1'b1;
        over_r <= {32'd0, n[63:32]} >= d;
        r_r    <= {32'd0, n[63:32]};
        bits_r <= {n[31:0], 9'd0};
        q_r    <= '0;
        d_r    <= d;
        cnt_r  <= 6'd41;
      end else if (busy_r) begin
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= (over_r || q_r > dd_odo_pkg::ARC_CAP) ? dd_odo_pkg::ARC_CAP : q_r;
        end else begin
          cnt_r  <= cnt_r - 1'b1;
          r_r    <= ge ? t_sub[63:0] : t[63:0];
          q_r    <= {q_r[39:0], ge};
          bits_r <= {bits_r[39:0], 1'b0};
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

>>> hw/rtl/differential_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Wheel odometry: encoder counts in, saturating Q16.16 pose and binary-angle
// heading out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries absolute left/right encoder counts, one beat per sample.
//   out_ch returns one pose beat (x, y, heading after the update) per input.
//   psel/penable/pwrite/paddr/pwdata write metres_per_tick (0x0),
//   inverse_wheel_base (0x4) and angle_only (0x8); reads return them.
// Sequence:
//   a sample is accepted only in the idle state, scaled to wheel distances
//   and turned into a heading step; the cordic then runs once (angle-only
//   mode or a straight step) or twice (arc step), and an arc step also calls
//   the bit-serial divider twice, all around one shared 34x34 multiplier.
//   The next sample is taken once the result is in the output register.
// Reset: rst_n clears pose, heading, previous counts and loads register
//   defaults. A stalled out_ch holds the result; the next sample is still
//   taken and worked on, then waits in its last step until the output
//   register frees, and further input is refused meanwhile.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top #(
  parameter int COUNT_WIDTH     = 32,
  parameter int TRIG_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  dd_odo_in_if.sink          in_ch,
  dd_odo_out_if.source       out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = COUNT_WIDTH;

  // configuration
  logic [31:0] mpt_r, ibase_r;
  logic        aonly_r;

  // state
  logic [CW-1:0]      prev_l_r, prev_r_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic [31:0]        heading_r;

  // working registers
  dd_odo_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]      delta_l_r, delta_r_r;
  logic signed [31:0] dl_r, dr_r;
  logic [63:0]        tm_r;
  logic [61:0]        ta_r;
  logic [31:0]        tb_r;
  logic               dneg_r;
  logic signed [31:0] c0_r, s0_r, c1_r, s1_r;
  logic signed [67:0] prod_r;
  logic               aneg_r;

  // output register
  logic               ov_r;
  logic signed [31:0] ox_r, oy_r;
  logic [31:0]        oh_r;

  // shared multiplier operands and unit strobes
  logic signed [33:0] mul_a, mul_b;
  logic               cor_start, div_start;
  logic [31:0]        cor_angle;
  dd_odo_pkg::cordic_res_t cor_res;
  dd_odo_pkg::div_res_t    div_res;

  logic signed [32:0] diff_v, sum_v, sdiff_y, sdiff_x;
  logic [32:0]        abs_diff, abs_sum, abs_sy, abs_sx;
  logic [62:0]        t_bam;
  logic [31:0]        tb_mag;
  logic               in_acc;

  function automatic logic signed [31:0] sat32(input logic signed [68:0] v);
    logic signed [31:0] r;
    if (v > 69'sd2147483647)       r = 32'sh7fff_ffff;
    else if (v < -69'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      dd_odo_pkg::REG_METRES_PER_TICK: prdata = mpt_r;
      dd_odo_pkg::REG_INV_WHEEL_BASE:  prdata = ibase_r;
      dd_odo_pkg::REG_ANGLE_ONLY:      prdata = {31'd0, aonly_r};
      default:                         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r   <= 32'd429497;
      ibase_r <= 32'd83886080;
      aonly_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        dd_odo_pkg::REG_METRES_PER_TICK: mpt_r   <= pwdata;
        dd_odo_pkg::REG_INV_WHEEL_BASE:  ibase_r <= pwdata;
        dd_odo_pkg::REG_ANGLE_ONLY:      aonly_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == dd_odo_pkg::ST_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.position_x = ox_r;
  assign out_ch.position_y = oy_r;
  assign out_ch.heading    = oh_r;

  // datapath helpers
  always_comb begin
    diff_v   = 33'(dl_r) - 33'(dr_r);
    sum_v    = 33'(dl_r) + 33'(dr_r);
    sdiff_y  = 33'(s1_r) - 33'(s0_r);
    sdiff_x  = 33'(c0_r) - 33'(c1_r);
    abs_diff = abs33(diff_v);
    abs_sum  = abs33(sum_v);
    abs_sy   = abs33(sdiff_y);
    abs_sx   = abs33(sdiff_x);
    t_bam    = {1'b0, ta_r} + {31'd0, prod_r[63:32]};
    tb_mag   = t_bam[39:8];
  end

  // sequencer and operand select
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    cor_angle = heading_r;
    div_start = 1'b0;
    case (state_r)
      dd_odo_pkg::ST_IDLE: if (in_acc) state_nxt = dd_odo_pkg::ST_DL;
      dd_odo_pkg::ST_DL: begin
        mul_a = 34'($signed(delta_l_r));
        mul_b = {2'b00, mpt_r};
        state_nxt = dd_odo_pkg::ST_DR;
      end
      dd_odo_pkg::ST_DR: begin
        mul_a = 34'($signed(delta_r_r));
        mul_b = {2'b00, mpt_r};
        state_nxt = dd_odo_pkg::ST_DS;
      end
      dd_odo_pkg::ST_DS: state_nxt = dd_odo_pkg::ST_TM;
      dd_odo_pkg::ST_TM: begin
        mul_a = {1'b0, abs_diff};
        mul_b = {2'b00, ibase_r};
        state_nxt = dd_odo_pkg::ST_BHI;
      end
      dd_odo_pkg::ST_BHI: begin
        mul_a = {2'b00, prod_r[63:32]};
        mul_b = {2'b00, dd_odo_pkg::INV_TWO_PI_Q32};
        state_nxt = dd_odo_pkg::ST_BLO;
      end
      dd_odo_pkg::ST_BLO: begin
        mul_a = {2'b00, tm_r[31:0]};
        mul_b = {2'b00, dd_odo_pkg::INV_TWO_PI_Q32};
        state_nxt = dd_odo_pkg::ST_BAM;
      end
      dd_odo_pkg::ST_BAM: begin
        cor_start = 1'b1;
        state_nxt = dd_odo_pkg::ST_COR0;
      end
      dd_odo_pkg::ST_COR0: if (cor_res.done) begin
        if (aonly_r) state_nxt = dd_odo_pkg::ST_DONE;
        else if (tb_r == 32'd0) state_nxt = dd_odo_pkg::ST_STR_Y;
        else begin
          cor_start = 1'b1;
          cor_angle = heading_r + tb_r;
          state_nxt = dd_odo_pkg::ST_COR1;
        end
      end
      dd_odo_pkg::ST_STR_Y: begin
        mul_a = 34'(dl_r);
        mul_b = 34'(c0_r);
        state_nxt = dd_odo_pkg::ST_STR_X;
      end
      dd_odo_pkg::ST_STR_X: begin
        mul_a = 34'(dl_r);
        mul_b = 34'(s0_r);
        state_nxt = dd_odo_pkg::ST_STR_FIN;
      end
      dd_odo_pkg::ST_STR_FIN: state_nxt = dd_odo_pkg::ST_DONE;
      dd_odo_pkg::ST_COR1: if (cor_res.done) state_nxt = dd_odo_pkg::ST_ARC_Y;
      dd_odo_pkg::ST_ARC_Y: begin
        mul_a = {1'b0, abs_sum};
        mul_b = {1'b0, abs_sy};
        state_nxt = dd_odo_pkg::ST_ARC_YD;
      end
      dd_odo_pkg::ST_ARC_YD: begin
        div_start = 1'b1;
        state_nxt = dd_odo_pkg::ST_ARC_YW;
      end
      dd_odo_pkg::ST_ARC_YW: if (div_res.done) state_nxt = dd_odo_pkg::ST_ARC_X;
      dd_odo_pkg::ST_ARC_X: begin
        mul_a = {1'b0, abs_sum};
        mul_b = {1'b0, abs_sx};
        state_nxt = dd_odo_pkg::ST_ARC_XD;
      end
      dd_odo_pkg::ST_ARC_XD: begin
        div_start = 1'b1;
        state_nxt = dd_odo_pkg::ST_ARC_XW;
      end
      dd_odo_pkg::ST_ARC_XW: if (div_res.done) state_nxt = dd_odo_pkg::ST_DONE;
      dd_odo_pkg::ST_DONE: if (!ov_r || out_ch.ready) state_nxt = dd_odo_pkg::ST_IDLE;
      default: state_nxt = dd_odo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dd_odo_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // shared units
  dd_odo_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
    .clk, .rst_n, .start(cor_start), .angle(cor_angle), .res(cor_res)
  );

  dd_odo_div u_div (
    .clk, .rst_n, .start(div_start), .n(prod_r[63:0]), .d(tm_r), .res(div_res)
  );

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      dd_odo_pkg::ST_IDLE: if (in_acc) begin
        delta_l_r <= in_ch.left_count[CW-1:0] - prev_l_r;
        delta_r_r <= in_ch.right_count[CW-1:0] - prev_r_r;
      end
      dd_odo_pkg::ST_DR: dl_r <= sat32(69'(prod_r >>> 16));
      dd_odo_pkg::ST_DS: dr_r <= sat32(69'(prod_r >>> 16));
      dd_odo_pkg::ST_TM: dneg_r <= diff_v[32];
      dd_odo_pkg::ST_BHI: tm_r <= prod_r[63:0];
      dd_odo_pkg::ST_BLO: ta_r <= prod_r[61:0];
      dd_odo_pkg::ST_BAM: tb_r <= dneg_r ? (32'd0 - tb_mag) : tb_mag;
      dd_odo_pkg::ST_COR0: if (cor_res.done) begin
        c0_r <= cor_res.cos_v;
        s0_r <= cor_res.sin_v;
      end
      dd_odo_pkg::ST_COR1: if (cor_res.done) begin
        c1_r <= cor_res.cos_v;
        s1_r <= cor_res.sin_v;
      end
      dd_odo_pkg::ST_ARC_Y: aneg_r <= sum_v[32] ^ sdiff_y[32] ^ dneg_r;
      dd_odo_pkg::ST_ARC_X: aneg_r <= sum_v[32] ^ sdiff_x[32] ^ dneg_r;
      default: ;
    endcase
  end

  // pose, heading and output register
  logic signed [41:0] arc_d;
  assign arc_d = aneg_r ? -$signed({1'b0, div_res.quot}) : $signed({1'b0, div_res.quot});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_l_r  <= '0;
      prev_r_r  <= '0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      // output beat loaded or taken
      if (state_r == dd_odo_pkg::ST_DONE && (!ov_r || out_ch.ready)) ov_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (in_acc) begin
        prev_l_r <= in_ch.left_count[CW-1:0];
        prev_r_r <= in_ch.right_count[CW-1:0];
      end
      case (state_r)
        dd_odo_pkg::ST_STR_X:   pos_y_r <= sat32(69'(pos_y_r) + 69'(prod_r >>> 30));
        dd_odo_pkg::ST_STR_FIN: pos_x_r <= sat32(69'(pos_x_r) + 69'(prod_r >>> 30));
        dd_odo_pkg::ST_ARC_YW: if (div_res.done) pos_y_r <= sat32(69'(pos_y_r) + 69'(arc_d));
        dd_odo_pkg::ST_ARC_XW: if (div_res.done) pos_x_r <= sat32(69'(pos_x_r) + 69'(arc_d));
        dd_odo_pkg::ST_DONE: if (!ov_r || out_ch.ready) begin
          heading_r <= heading_r + tb_r;
          ox_r      <= pos_x_r;
          oy_r      <= pos_y_r;
          oh_r      <= heading_r + tb_r;
        end
        default: ;
      endcase
    end
  end

  // checks
  a_heading_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(heading_r) |-> $past(state_r) == dd_odo_pkg::ST_DONE)
    else $error("heading changed outside the result step");

  a_div_capped: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> div_res.quot <= dd_odo_pkg::ARC_CAP)
    else $error("arc step above cap");

  a_pose_held_in_angle_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (aonly_r && $past(aonly_r) && state_r != dd_odo_pkg::ST_IDLE) |=>
      $stable(pos_x_r) && $stable(pos_y_r))
    else $error("position moved in angle-only mode");

endmodule
